/* hw/rtl/page_bitmap_allocator_macros.svh */
// assertion macros shared by the page bitmap allocator rtl
`ifndef PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked on clk and disabled in reset
`define PBA_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("page bitmap allocator check failed");

// next-cycle implication, checked on clk and disabled in reset
`define PBA_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("page bitmap allocator check failed");

`endif

/* hw/rtl/pba_pkg.sv */
// types and constants of the page bitmap allocator
`default_nettype none

package pba_pkg;

  localparam int ADDR_W = 48;
  localparam int BLK_W  = 27;
  localparam int CNT_W  = 28;

  localparam logic [2:0] FUNC_ALLOC     = 3'd0;
  localparam logic [2:0] FUNC_RELEASE   = 3'd1;
  localparam logic [2:0] FUNC_MARK_FREE = 3'd2;
  localparam logic [2:0] FUNC_MARK_USED = 3'd3;
  localparam logic [2:0] FUNC_QUERY     = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  localparam logic [7:0] BYTE_ALL_USED = 8'hFF;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SETUP,
    S_CLAMP,
    S_RD,
    S_MOD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ALU_SET,
    ALU_CLR,
    ALU_FIND,
    ALU_COUNT
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [2:0] lo;
    logic [2:0] hi;
  } alu_ctl_t;

  typedef struct packed {
    logic [7:0] new_byte;
    logic       has_zero;
    logic [2:0] zero_bit;
    logic [3:0] ones;
  } alu_res_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [ADDR_W-1:0] byte_address;
    logic [ADDR_W-1:0] byte_length;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [BLK_W-1:0]  block_addr;
    logic [ADDR_W-1:0] total_bytes;
    logic [CNT_W-1:0]  used_bytes;
    logic [CNT_W-1:0]  free_bytes;
  } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/pba_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/pba_byte_alu.sv */
// shared byte unit: range mask update, lowest clear bit search, popcount
`default_nettype none

module pba_byte_alu import pba_pkg::*; (
  input  wire logic [7:0] rd_byte,
  input  wire alu_ctl_t   ctl,
  output alu_res_t        res
);

  logic [7:0] mask;
  logic       has_zero;
  logic [2:0] zero_bit;
  logic [3:0] ones;

  always_comb begin
    mask     = '0;
    has_zero = 1'b0;
    zero_bit = '0;
    ones     = '0;
    for (int i = 0; i < 8; i++) begin
      mask[i] = (3'(i) >= ctl.lo) && (3'(i) <= ctl.hi);
      ones    = ones + 4'(rd_byte[i]);
    end
    // walk downward so the lowest clear bit wins
    for (int i = 7; i >= 0; i--) begin
      if (!rd_byte[i]) begin
        has_zero = 1'b1;
        zero_bit = 3'(i);
      end
    end
  end

  always_comb begin
    res.has_zero = has_zero;
    res.zero_bit = zero_bit;
    res.ones     = ones;
    case (ctl.op)
      ALU_SET:  res.new_byte = rd_byte | mask;
      ALU_CLR:  res.new_byte = rd_byte & ~mask;
      ALU_FIND: res.new_byte = rd_byte | (8'b1 << zero_bit);
      default:  res.new_byte = rd_byte;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/page_bitmap_allocator.sv */
// page bitmap allocator top level: command sequencer, counters and bitmap ram
//
// One command at a time: a command is taken when start is high and busy is low,
// and its single result appears on rsp for exactly one cycle with done high; the
// receiver must take it then. The bitmap lives in a byte-wide ram with one read
// and one write port, and every byte visited is read in S_RD, then modified and
// written back through the shared byte unit in S_MOD. Allocate scans the bytes
// up to the first byte with a clear bit (the whole window when none is free);
// query scans the whole window; release touches one byte, none when the page is
// past the page limit, and mark free or mark used touch the bytes of the range,
// none when nothing is touched. Unknown function codes answer without touching
// the map. After reset a clearing pass writes every map byte as used, with busy
// held high.
`default_nettype none

`include "page_bitmap_allocator_macros.svh"

module page_bitmap_allocator import pba_pkg::*; #(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_PAGES  = 32768,
  parameter int MAP_BYTES  = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output rsp_t      rsp
);

  localparam int S    = $clog2(PAGE_BYTES);
  localparam int LIM  = (MAX_PAGES < MAP_BYTES * 8) ? MAX_PAGES : MAP_BYTES * 8;
  localparam int PW   = $clog2(LIM + 1);
  localparam int TW   = $clog2(MAX_PAGES + 1);
  localparam int AW   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CNTW = $clog2(MAP_BYTES * 8 + 1);
  localparam int RW   = ADDR_W + 2;

  localparam logic [RW-1:0] PB_M1  = RW'(PAGE_BYTES - 1);
  localparam logic [RW-1:0] LIM_RW = RW'(LIM);
  localparam logic [RW-1:0] MAX_RW = RW'(MAX_PAGES);
  localparam logic [AW-1:0] LAST_A = AW'(MAP_BYTES - 1);

  state_t state, state_next;

  cmd_t              cmd_q;
  logic [RW-1:0]     rs, re;
  logic [AW-1:0]     ptr, first_b, last_b;
  logic [2:0]        lo_bits, hi_bits;
  logic [CNTW-1:0]   cnt;
  logic [TW-1:0]     top;
  logic [ADDR_W-1:0] total;
  logic [1:0]        status_q;
  logic [BLK_W-1:0]  blk_q;

  // ram and byte unit
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  alu_ctl_t      alu_ctl;
  alu_res_t      alu_res;

  // setup and clamp arithmetic
  logic [RW-1:0]     sum_al;
  logic [RW-1:0]     rs_set, re_set;
  logic [31:0]       win;
  logic              win_zero;
  logic [AW-1:0]     win_last;
  logic [ADDR_W:0]   tsum;
  logic [TW-1:0]     e_free;
  logic [RW-1:0]     e_src;
  logic [PW-1:0]     s_c, e_c, e_m1;
  logic              rel_out;
  logic              range_empty;
  logic              at_last;
  logic [63:0]       blk64;
  logic [63:0]       used64, managed64, free64;

  pba_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  pba_byte_alu u_alu (
    .rd_byte (ram_rdata),
    .ctl     (alu_ctl),
    .res     (alu_res)
  );

  always_comb begin
    sum_al = RW'(cmd_q.byte_address) + RW'(cmd_q.byte_length);
    if (cmd_q.func == FUNC_MARK_FREE) begin
      // inward rounding
      rs_set = (RW'(cmd_q.byte_address) + PB_M1) >> S;
      re_set = sum_al >> S;
    end else begin
      // outward rounding, release uses the start only
      rs_set = RW'(cmd_q.byte_address) >> S;
      re_set = (sum_al + PB_M1) >> S;
    end

    win = (32'(top) + 32'd7) >> 3;
    if (win > 32'(MAP_BYTES)) begin
      win = 32'(MAP_BYTES);
    end
    win_zero = (win == 32'd0);
    win_last = AW'(win - 32'd1);

    tsum = {1'b0, total} + {1'b0, cmd_q.byte_length};

    e_free  = (re > MAX_RW) ? TW'(MAX_PAGES) : TW'(re);
    e_src   = (cmd_q.func == FUNC_MARK_FREE) ? RW'(e_free) : re;
    rel_out = (rs >= LIM_RW);
    s_c     = (rs > LIM_RW) ? PW'(LIM) : PW'(rs);
    if (cmd_q.func == FUNC_RELEASE) begin
      e_c = s_c + PW'(1);
    end else begin
      e_c = (e_src > LIM_RW) ? PW'(LIM) : PW'(e_src);
    end
    range_empty = (s_c >= e_c);
    e_m1        = e_c - PW'(1);

    at_last   = (ptr == last_b);
    blk64     = 64'({ptr, alu_res.zero_bit}) << S;
    used64    = 64'(cnt) << S;
    managed64 = 64'(top) << S;
    free64    = (managed64 > used64) ? managed64 - used64 : 64'd0;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (ptr == LAST_A) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        unique case (cmd_q.func) inside
          FUNC_ALLOC, FUNC_QUERY: state_next = win_zero ? S_DONE : S_RD;
          FUNC_RELEASE, FUNC_MARK_FREE, FUNC_MARK_USED: state_next = S_CLAMP;
          default: state_next = S_DONE;
        endcase
      end
      S_CLAMP: begin
        if (((cmd_q.func == FUNC_RELEASE) && rel_out) || range_empty) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: state_next = S_MOD;
      S_MOD: begin
        if (at_last || ((alu_ctl.op == ALU_FIND) && alu_res.has_zero)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RD;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy       = (state != S_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = ptr;
    ram_wdata  = alu_res.new_byte;
    alu_ctl.lo = (ptr == first_b) ? lo_bits : 3'd0;
    alu_ctl.hi = at_last ? hi_bits : 3'd7;
    unique case (cmd_q.func) inside
      FUNC_ALLOC:     alu_ctl.op = ALU_FIND;
      FUNC_QUERY:     alu_ctl.op = ALU_COUNT;
      FUNC_MARK_USED: alu_ctl.op = ALU_SET;
      default:        alu_ctl.op = ALU_CLR;
    endcase
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = BYTE_ALL_USED;
      end
      S_MOD: begin
        ram_we = (alu_ctl.op == ALU_SET) || (alu_ctl.op == ALU_CLR) ||
                 ((alu_ctl.op == ALU_FIND) && alu_res.has_zero);
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      ptr   <= '0;
      top   <= '0;
      total <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_DONE);
      case (state)
        S_INIT: begin
          ptr <= (ptr == LAST_A) ? '0 : ptr + AW'(1);
        end
        S_IDLE: begin
          if (start) begin
            cmd_q    <= cmd;
            status_q <= STAT_OK;
            blk_q    <= '0;
            cnt      <= '0;
          end
        end
        S_SETUP: begin
          rs     <= rs_set;
          re     <= re_set;
          ptr    <= '0;
          last_b <= win_last;
          if (cmd_q.func == FUNC_MARK_FREE) begin
            total <= tsum[ADDR_W] ? '1 : tsum[ADDR_W-1:0];
          end
          if ((cmd_q.func == FUNC_ALLOC) && win_zero) begin
            status_q <= STAT_NO_FREE;
          end
        end
        S_CLAMP: begin
          ptr     <= AW'(s_c >> 3);
          first_b <= AW'(s_c >> 3);
          last_b  <= AW'(e_m1 >> 3);
          lo_bits <= s_c[2:0];
          hi_bits <= e_m1[2:0];
          // top moves even when the range clears nothing
          if ((cmd_q.func == FUNC_MARK_FREE) && (e_free > top)) begin
            top <= e_free;
          end
          if ((cmd_q.func == FUNC_RELEASE) && rel_out) begin
            status_q <= STAT_IGNORED;
          end
        end
        S_MOD: begin
          if (alu_ctl.op == ALU_FIND) begin
            if (alu_res.has_zero) begin
              blk_q <= blk64[BLK_W-1:0];
            end else if (at_last) begin
              status_q <= STAT_NO_FREE;
            end
          end
          if (alu_ctl.op == ALU_COUNT) begin
            cnt <= cnt + CNTW'(alu_res.ones);
          end
          if (!at_last) begin
            ptr <= ptr + AW'(1);
          end
        end
        S_DONE: begin
          rsp.status     <= status_q;
          rsp.block_addr <= blk_q;
          if (cmd_q.func == FUNC_QUERY) begin
            rsp.total_bytes <= total;
            rsp.used_bytes  <= used64[CNT_W-1:0];
            rsp.free_bytes  <= free64[CNT_W-1:0];
          end else begin
            rsp.total_bytes <= '0;
            rsp.used_bytes  <= '0;
            rsp.free_bytes  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `PBA_ASSERT_IMP(a_done_idle, done, !busy)
  `PBA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `PBA_ASSERT_IMP(a_nofree_zero, done && (rsp.status == STAT_NO_FREE), rsp.block_addr == '0)
  `PBA_ASSERT_IMP(a_wr_in_span, ram_we && (state == S_MOD), ptr <= last_b)

endmodule

`default_nettype wire
